// ===== rtl/core/jet_pkg.sv =====
// Shared types, widths and register codes for the Julia escape-time core.
// Used by every module of the core; depends on nothing.
package jet_pkg;

   localparam int Q_W       = 32;
   localparam int FRAC_W    = 26;
   localparam int PIX_W     = 12;
   localparam int MAG_W     = 40;
   localparam int ITER_W    = 16;
   localparam int PROD_W    = 2 * Q_W;
   localparam int START_W   = PIX_W + 1 + Q_W;
   localparam int SAT_W     = START_W + 1;
   localparam int CSR_IDX_W = 3;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_C_REAL     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_C_IMAG     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RE_ORIGIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RE_STEP    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IM_ORIGIN  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_IM_STEP    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE_SQ  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_ITER_LIMIT = 3'd7;

   localparam logic [MAG_W-1:0]  ESCAPE_SQ_RESET  = 40'd268435456;
   localparam logic [ITER_W-1:0] ITER_LIMIT_RESET = 16'd255;

   typedef struct packed {
      logic [Q_W-1:0]    c_real;
      logic [Q_W-1:0]    c_imag;
      logic [Q_W-1:0]    re_origin;
      logic [Q_W-1:0]    re_step;
      logic [Q_W-1:0]    im_origin;
      logic [Q_W-1:0]    im_step;
      logic [MAG_W-1:0]  escape_sq;
      logic [ITER_W-1:0] iter_limit;
   } cfg_type;

   typedef struct packed {
      logic [PIX_W-1:0] x;
      logic [PIX_W-1:0] y;
      logic [Q_W-1:0]   zr;
      logic [Q_W-1:0]   zi;
   } point_type;

   // Clamps a signed value to the signed Q6.26 range.
   function automatic logic [Q_W-1:0] sat_q(input logic signed [SAT_W-1:0] v);
      logic signed [SAT_W-1:0] hi;
      logic signed [SAT_W-1:0] lo;
      hi = SAT_W'({1'b0, {(Q_W-1){1'b1}}});
      lo = -hi - SAT_W'(1);
      if (v > hi) begin
         sat_q = hi[Q_W-1:0];
      end else if (v < lo) begin
         sat_q = lo[Q_W-1:0];
      end else begin
         sat_q = v[Q_W-1:0];
      end
   endfunction

endpackage

// ===== rtl/core/jet_front.sv =====
// Front end: accepts pixel transactions and maps them to start points.
// Depends on jet_pkg; feeds jet_queue.
module jet_front (
   input  logic                    clock,
   input  logic                    reset,
   input  jet_pkg::cfg_type        cfg,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [jet_pkg::PIX_W-1:0] req_pixel_x,
   input  logic [jet_pkg::PIX_W-1:0] req_pixel_y,
   output logic                    push,
   output jet_pkg::point_type      push_data,
   input  logic                    q_full
);
   import jet_pkg::*;

   logic                      stage_valid_ff, stage_valid_in;
   logic [PIX_W-1:0]          x_ff, y_ff;
   logic signed [START_W-1:0] prod_re_ff, prod_im_ff;
   logic signed [START_W-1:0] prod_re_in, prod_im_in;
   logic signed [SAT_W-1:0]   sum_re, sum_im;
   logic                      accept;

   assign prod_re_in = $signed({1'b0, req_pixel_x}) * $signed(cfg.re_step);
   assign prod_im_in = $signed({1'b0, req_pixel_y}) * $signed(cfg.im_step);

   assign push      = stage_valid_ff && !q_full;
   assign req_stall = stage_valid_ff && q_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (push) begin
         stage_valid_in = 1'b0;
      end
   end

   assign sum_re = SAT_W'(prod_re_ff) + SAT_W'($signed(cfg.re_origin));
   assign sum_im = SAT_W'(prod_im_ff) + SAT_W'($signed(cfg.im_origin));

   assign push_data.x  = x_ff;
   assign push_data.y  = y_ff;
   assign push_data.zr = sat_q(sum_re);
   assign push_data.zi = sat_q(sum_im);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff       <= req_pixel_x;
         y_ff       <= req_pixel_y;
         prod_re_ff <= prod_re_in;
         prod_im_ff <= prod_im_in;
      end
   end

endmodule

// ===== rtl/core/jet_queue.sv =====
// Short queue of start points between the front end and the iteration engine.
// Depends on jet_pkg.
module jet_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  jet_pkg::point_type push_data,
   output logic               full,
   input  logic               pop,
   output jet_pkg::point_type pop_data,
   output logic               empty
);
   import jet_pkg::*;

   point_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/jet_back.sv =====
// Iteration engine: runs z = z*z + c on one point and holds the result transaction.
// Depends on jet_pkg; reads start points from jet_queue.
module jet_back (
   input  logic                       clock,
   input  logic                       reset,
   input  jet_pkg::cfg_type           cfg,
   input  logic                       q_empty,
   input  jet_pkg::point_type         pop_data,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [jet_pkg::PIX_W-1:0]  rsp_out_x,
   output logic [jet_pkg::PIX_W-1:0]  rsp_out_y,
   output logic                       rsp_escaped,
   output logic [jet_pkg::ITER_W-1:0] rsp_escape_iter
);
   import jet_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL  = 2'd1;
   localparam logic [1:0] S_ADD  = 2'd2;
   localparam logic [1:0] S_FIN  = 2'd3;

   logic [1:0]               state_ff, state_in;
   logic [PIX_W-1:0]         x_ff, x_in, y_ff, y_in;
   logic signed [Q_W-1:0]    zr_ff, zr_in, zi_ff, zi_in;
   logic [ITER_W-1:0]        n_ff, n_in;
   logic                     esc_ff, esc_in;
   logic signed [PROD_W-1:0] rr_ff, ii_ff, ri_ff;
   logic signed [PROD_W-1:0] rr_in, ii_in, ri_in;
   logic signed [PROD_W-1:0] diff;
   logic [PROD_W-1:0]        mag_sum;
   logic [MAG_W-1:0]         mag;
   logic                     over;
   logic signed [SAT_W-1:0]  re_sum, im_sum;
   logic                     out_valid_ff, out_valid_in;
   logic                     out_load;
   logic [PIX_W-1:0]         out_x_ff, out_y_ff;
   logic                     out_esc_ff;
   logic [ITER_W-1:0]        out_iter_ff;

   assign rr_in = zr_ff * zr_ff;
   assign ii_in = zi_ff * zi_ff;
   assign ri_in = zr_ff * zi_ff;

   assign diff    = rr_ff - ii_ff;
   assign re_sum  = SAT_W'($signed(diff[PROD_W-1:FRAC_W])) + SAT_W'($signed(cfg.c_real));
   assign im_sum  = SAT_W'($signed(ri_ff[PROD_W-1:FRAC_W-1])) + SAT_W'($signed(cfg.c_imag));
   assign mag_sum = $unsigned(rr_ff) + $unsigned(ii_ff);
   assign mag     = MAG_W'(mag_sum[PROD_W-1:FRAC_W]);
   assign over    = mag > cfg.escape_sq;

   assign pop      = (state_ff == S_IDLE) && !q_empty;
   assign out_load = (state_ff == S_FIN) && (!out_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      zr_in    = zr_ff;
      zi_in    = zi_ff;
      n_in     = n_ff;
      esc_in   = esc_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               x_in   = pop_data.x;
               y_in   = pop_data.y;
               zr_in  = $signed(pop_data.zr);
               zi_in  = $signed(pop_data.zi);
               n_in   = '0;
               esc_in = 1'b0;
               state_in = (cfg.iter_limit == '0) ? S_FIN : S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_ADD;
         end
         S_ADD: begin
            if (n_ff != '0 && over) begin
               esc_in   = 1'b1;
               state_in = S_FIN;
            end else if (n_ff == cfg.iter_limit) begin
               esc_in   = 1'b0;
               state_in = S_FIN;
            end else begin
               zr_in    = $signed(sat_q(re_sum));
               zi_in    = $signed(sat_q(im_sum));
               n_in     = n_ff + 1'b1;
               state_in = S_MUL;
            end
         end
         S_FIN: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      if (out_load) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      zr_ff  <= zr_in;
      zi_ff  <= zi_in;
      n_ff   <= n_in;
      esc_ff <= esc_in;
      rr_ff  <= rr_in;
      ii_ff  <= ii_in;
      ri_ff  <= ri_in;
      if (out_load) begin
         out_x_ff    <= x_ff;
         out_y_ff    <= y_ff;
         out_esc_ff  <= esc_ff;
         out_iter_ff <= esc_ff ? n_ff : '0;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_x       = out_x_ff;
   assign rsp_out_y       = out_y_ff;
   assign rsp_escaped     = out_esc_ff;
   assign rsp_escape_iter = out_iter_ff;

endmodule

// ===== rtl/core/julia_escape_time_core.sv =====
// A pixel transaction passes the front-end register, the queue, the engine's multiply and
// add states once per iteration, and the result register before its result leaves.
// The engine works on one point at a time in its shared multiply/add loop and pops no new point
// until the last result is loaded; a zero iteration limit sends a point straight to the result state.
// The front end and a two-entry queue take new transactions while the engine is busy.
// Synchronous active-high reset empties the pipeline and queue and loads register defaults.
module julia_escape_time_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wen,
   input  logic [jet_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [jet_pkg::MAG_W-1:0]        csr_wdata,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [jet_pkg::PIX_W-1:0]        req_pixel_x,
   input  logic [jet_pkg::PIX_W-1:0]        req_pixel_y,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [jet_pkg::PIX_W-1:0]        rsp_out_x,
   output logic [jet_pkg::PIX_W-1:0]        rsp_out_y,
   output logic                             rsp_escaped,
   output logic [jet_pkg::ITER_W-1:0]       rsp_escape_iter
);
   import jet_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      push, pop, q_full, q_empty;
   point_type push_data, pop_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_C_REAL:     cfg_in.c_real     = csr_wdata[Q_W-1:0];
            CSR_C_IMAG:     cfg_in.c_imag     = csr_wdata[Q_W-1:0];
            CSR_RE_ORIGIN:  cfg_in.re_origin  = csr_wdata[Q_W-1:0];
            CSR_RE_STEP:    cfg_in.re_step    = csr_wdata[Q_W-1:0];
            CSR_IM_ORIGIN:  cfg_in.im_origin  = csr_wdata[Q_W-1:0];
            CSR_IM_STEP:    cfg_in.im_step    = csr_wdata[Q_W-1:0];
            CSR_ESCAPE_SQ:  cfg_in.escape_sq  = csr_wdata;
            CSR_ITER_LIMIT: cfg_in.iter_limit = csr_wdata[ITER_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.c_real     <= '0;
         cfg_ff.c_imag     <= '0;
         cfg_ff.re_origin  <= '0;
         cfg_ff.re_step    <= '0;
         cfg_ff.im_origin  <= '0;
         cfg_ff.im_step    <= '0;
         cfg_ff.escape_sq  <= ESCAPE_SQ_RESET;
         cfg_ff.iter_limit <= ITER_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   jet_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_pixel_x (req_pixel_x),
      .req_pixel_y (req_pixel_y),
      .push        (push),
      .push_data   (push_data),
      .q_full      (q_full)
   );

   jet_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   jet_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_empty         (q_empty),
      .pop_data        (pop_data),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_escaped     (rsp_escaped),
      .rsp_escape_iter (rsp_escape_iter)
   );

endmodule

// ===== rtl/core/jet_checker.sv =====
// Port-level checks for the Julia escape-time core, bound to its top level.
// Depends on jet_pkg and julia_escape_time_core.
module jet_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [jet_pkg::PIX_W-1:0]  rsp_out_x,
   input logic [jet_pkg::PIX_W-1:0]  rsp_out_y,
   input logic                       rsp_escaped,
   input logic [jet_pkg::ITER_W-1:0] rsp_escape_iter
);
   import jet_pkg::*;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result transaction visible right after reset");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result transaction dropped");

   a_hold_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_out_x) && $stable(rsp_out_y)
         && $stable(rsp_escaped) && $stable(rsp_escape_iter))
      else $error("stalled result payload changed");

   a_no_escape_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_escaped |-> rsp_escape_iter == '0)
      else $error("escape iteration set for a point that did not escape");

   a_escape_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_escaped |-> rsp_escape_iter != '0)
      else $error("escaped point reports iteration zero");

endmodule

bind julia_escape_time_core jet_checker u_jet_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_x       (rsp_out_x),
   .rsp_out_y       (rsp_out_y),
   .rsp_escaped     (rsp_escaped),
   .rsp_escape_iter (rsp_escape_iter)
);
